// ----- rtl/crfill_pkg.sv -----
package crfill_pkg;

   // frame store geometry, fixed row stride of MAX_WIDTH
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 64;
   localparam int FRAC_BITS  = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;

   // configuration registers
   localparam int SW_W       = 8;
   localparam int SH_W       = 7;
   localparam int XOFF_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET      = 2'd2;

   localparam logic [SW_W-1:0]   SCREEN_WIDTH_RESET  = 8'd128;
   localparam logic [SH_W-1:0]   SCREEN_HEIGHT_RESET = 7'd64;
   localparam logic [XOFF_W-1:0] X_OFFSET_RESET      = 15'd8192;
   localparam logic [CHAN_W-1:0] ALPHA_MIN           = 8'd128;

   // scaling datapath widths
   localparam int Q_W    = 18;            // signed operand before scaling
   localparam int MAG_W  = 17;            // magnitude of the operand
   localparam int PROD_W = MAG_W + SH_W;  // magnitude times height
   localparam int CRD_W  = 12;            // signed pixel coordinate
   localparam int CLP_W  = 13;            // clipping arithmetic

   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_W,
      SEL_H
   } scale_sel_type;

   typedef struct packed {
      logic                     req_type;
      logic signed [15:0]       rect_x;
      logic signed [15:0]       rect_y;
      logic [14:0]              rect_w;
      logic [14:0]              rect_h;
      logic [CHAN_W-1:0]        fill_red;
      logic [CHAN_W-1:0]        fill_green;
      logic [CHAN_W-1:0]        fill_blue;
      logic [CHAN_W-1:0]        fill_alpha;
      logic [COL_W-1:0]         read_col;
      logic [ROW_W-1:0]         read_row;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] pixel_red;
      logic [CHAN_W-1:0] pixel_green;
      logic [CHAN_W-1:0] pixel_blue;
      logic              fill_drawn;
   } rsp_item_type;

   typedef struct packed {
      logic          accept;
      logic          scale_en;
      scale_sel_type scale_sel;
      logic          clip;
      logic          check;
      logic          fill_step;
      logic          clear_step;
      logic          rd_cap;
      logic          load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_read;
      logic drop;
      logic fill_last;
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/crfill_if.sv -----
interface crfill_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] rect_x;
   logic signed [15:0] rect_y;
   logic [14:0]        rect_w;
   logic [14:0]        rect_h;
   logic [7:0]         fill_red;
   logic [7:0]         fill_green;
   logic [7:0]         fill_blue;
   logic [7:0]         fill_alpha;
   logic [6:0]         read_col;
   logic [5:0]         read_row;

   modport source (
      output valid, req_type, rect_x, rect_y, rect_w, rect_h,
             fill_red, fill_green, fill_blue, fill_alpha, read_col, read_row,
      input  ready
   );
   modport sink (
      input  valid, req_type, rect_x, rect_y, rect_w, rect_h,
             fill_red, fill_green, fill_blue, fill_alpha, read_col, read_row,
      output ready
   );
endinterface

interface crfill_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   logic       fill_drawn;

   modport source (
      output valid, pixel_red, pixel_green, pixel_blue, fill_drawn,
      input  ready
   );
   modport sink (
      input  valid, pixel_red, pixel_green, pixel_blue, fill_drawn,
      output ready
   );
endinterface

// ----- rtl/crfill_ram.sv -----
module crfill_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/crfill_dp.sv -----
module crfill_dp import crfill_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  req_item_type          req_item,
   output rsp_item_type          rsp_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

   // configuration
   logic [SW_W-1:0]   screen_width_ff;
   logic [SH_W-1:0]   screen_height_ff;
   logic [XOFF_W-1:0] x_offset_ff;
   logic [SW_W-1:0]   w_eff;
   logic [SH_W-1:0]   h_eff;

   // captured item
   req_item_type req_ff;

   // scaling
   logic signed [Q_W-1:0]   q_sel;
   logic signed [Q_W-1:0]   q_abs;
   logic [MAG_W-1:0]        q_mag;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W-1:0]       prod_ff;
   logic                    prod_neg_ff;
   scale_sel_type           prod_sel_ff;
   logic                    prod_vld_ff;
   logic [CRD_W-1:0]        scaled_mag;
   logic signed [CRD_W-1:0] scaled;
   logic signed [CRD_W-1:0] nx_ff, ny_ff, nw_ff, nh_ff;

   // clipping
   logic signed [CLP_W-1:0] nx13, ny13, nw13, nh13, w13, h13;
   logic signed [CLP_W-1:0] end_x, end_y, endc_x, endc_y;
   logic signed [CLP_W-1:0] start_x, start_y, last_x, last_y;
   logic                    drop_in;
   logic                    drop_ff;
   logic [COL_W-1:0]        start_col_ff, last_col_ff, cur_col_ff;
   logic [ROW_W-1:0]        start_row_ff, last_row_ff, cur_row_ff;

   // store access
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_wdata;
   logic [PIX_W-1:0]  ram_rdata;
   logic [PIX_W-1:0]  colour;

   // result
   logic [PIX_W-1:0] pix_ff;
   logic             drawn_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         x_offset_ff      <= X_OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[SW_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[SH_W-1:0];
            CSR_X_OFFSET:      x_offset_ff      <= csr_wdata[XOFF_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize saturates to the store size
   always_comb begin
      if (screen_width_ff == '0) begin
         w_eff = SW_W'(1);
      end else if (screen_width_ff > SW_W'(MAX_WIDTH)) begin
         w_eff = SW_W'(MAX_WIDTH);
      end else begin
         w_eff = screen_width_ff;
      end
      if (screen_height_ff == '0) begin
         h_eff = SH_W'(1);
      end else if (screen_height_ff > SH_W'(MAX_HEIGHT)) begin
         h_eff = SH_W'(MAX_HEIGHT);
      end else begin
         h_eff = screen_height_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
   end

   // one scale per cycle: sign-magnitude multiply by the height
   always_comb begin
      unique case (cmd.scale_sel)
         SEL_X: q_sel = Q_W'(req_ff.rect_x) + Q_W'(x_offset_ff);
         SEL_Y: q_sel = ONE_Q - Q_W'(req_ff.rect_y);
         SEL_W: q_sel = Q_W'(req_ff.rect_w);
         SEL_H: q_sel = Q_W'(req_ff.rect_h);
         default: q_sel = '0;
      endcase
      q_abs   = q_sel[Q_W-1] ? -q_sel : q_sel;
      q_mag   = q_abs[MAG_W-1:0];
      prod_in = PROD_W'(q_mag) * PROD_W'(h_eff);
   end

   // truncation toward zero of both divisions is one shift of the magnitude
   assign scaled_mag = CRD_W'(prod_ff >> (FRAC_BITS + 1));
   assign scaled     = prod_neg_ff ? -scaled_mag : scaled_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.scale_en;
      end
      if (cmd.scale_en) begin
         prod_ff     <= prod_in;
         prod_neg_ff <= q_sel[Q_W-1];
         prod_sel_ff <= cmd.scale_sel;
      end
      if (prod_vld_ff) begin
         unique case (prod_sel_ff)
            SEL_X: nx_ff <= scaled;
            SEL_Y: ny_ff <= scaled;
            SEL_W: nw_ff <= scaled;
            SEL_H: nh_ff <= scaled;
            default: ;
         endcase
      end
   end

   always_comb begin
      nx13    = CLP_W'(nx_ff);
      ny13    = CLP_W'(ny_ff);
      nw13    = CLP_W'(nw_ff);
      nh13    = CLP_W'(nh_ff);
      w13     = CLP_W'(w_eff);
      h13     = CLP_W'(h_eff);
      end_x   = nx13 + nw13;
      end_y   = ny13 + nh13;
      endc_x  = (end_x > w13) ? w13 : end_x;
      endc_y  = (end_y > h13) ? h13 : end_y;
      start_x = nx13[CLP_W-1] ? '0 : nx13;
      start_y = ny13[CLP_W-1] ? '0 : ny13;
      // an empty span still gets its first column or row
      last_x  = (endc_x > start_x) ? endc_x - CLP_W'(1) : start_x;
      last_y  = (endc_y > start_y) ? endc_y - CLP_W'(1) : start_y;
      drop_in = (nx13 >= w13) || (ny13 >= h13) || (req_ff.fill_alpha < ALPHA_MIN);
   end

   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         drop_ff      <= drop_in;
         start_col_ff <= start_x[COL_W-1:0];
         last_col_ff  <= last_x[COL_W-1:0];
         start_row_ff <= start_y[ROW_W-1:0];
         last_row_ff  <= last_y[ROW_W-1:0];
      end
      if (cmd.check) begin
         cur_col_ff <= start_col_ff;
         cur_row_ff <= start_row_ff;
      end else if (cmd.fill_step) begin
         if (cur_col_ff == last_col_ff) begin
            cur_col_ff <= start_col_ff;
            cur_row_ff <= cur_row_ff + ROW_W'(1);
         end else begin
            cur_col_ff <= cur_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   assign colour = {req_ff.fill_red, req_ff.fill_green, req_ff.fill_blue};

   always_comb begin
      ram_we = cmd.clear_step || cmd.fill_step;
      priority if (cmd.clear_step) begin
         ram_addr  = clr_addr_ff;
         ram_wdata = '0;
      end else if (cmd.fill_step) begin
         ram_addr  = {cur_row_ff, cur_col_ff};
         ram_wdata = colour;
      end else begin
         ram_addr  = {req_ff.read_row, req_ff.read_col};
         ram_wdata = colour;
      end
   end

   crfill_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff   <= '0;
         drawn_ff <= 1'b0;
      end else if (cmd.check) begin
         drawn_ff <= !drop_ff;
      end else if (cmd.rd_cap) begin
         pix_ff <= ram_rdata;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.pixel_red   <= pix_ff[PIX_W-1 -: CHAN_W];
         rsp_ff.pixel_green <= pix_ff[CHAN_W +: CHAN_W];
         rsp_ff.pixel_blue  <= pix_ff[CHAN_W-1:0];
         rsp_ff.fill_drawn  <= drawn_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign status.is_read    = req_ff.req_type;
   assign status.drop       = drop_ff;
   assign status.fill_last  = (cur_col_ff == last_col_ff) && (cur_row_ff == last_row_ff);
   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   a_fill_in_active: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (SW_W'(cur_col_ff) < w_eff) && (SH_W'(cur_row_ff) < h_eff))
      else $error("fill write outside the active area");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while still held");

endmodule

// ----- rtl/crfill_ctrl.sv -----
module crfill_ctrl import crfill_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCALE,
      S_DRAIN,
      S_CLIP,
      S_CHECK,
      S_FILL,
      S_RDCAP,
      S_DONE
   } state_type;

   state_type     state_ff;
   scale_sel_type step_ff;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= SEL_X;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               step_ff  <= SEL_X;
               state_ff <= status.is_read ? S_RDCAP : S_SCALE;
            end
            S_SCALE: begin
               step_ff <= scale_sel_type'(step_ff + 2'd1);
               if (step_ff == SEL_H) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_CLIP;
            S_CLIP:  state_ff <= S_CHECK;
            S_CHECK: state_ff <= status.drop ? S_DONE : S_FILL;
            S_FILL: begin
               if (status.fill_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_RDCAP: state_ff <= S_DONE;
            S_DONE: begin
               if (status.rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.scale_sel = step_ff;
      unique case (state_ff)
         S_CLEAR:  cmd.clear_step = 1'b1;
         S_IDLE:   cmd.accept     = req_valid && !reset;
         S_DECODE: ;
         S_SCALE:  cmd.scale_en   = 1'b1;
         S_DRAIN:  ;
         S_CLIP:   cmd.clip       = 1'b1;
         S_CHECK:  cmd.check      = 1'b1;
         S_FILL:   cmd.fill_step  = 1'b1;
         S_RDCAP:  cmd.rd_cap     = 1'b1;
         S_DONE:   cmd.load_rsp   = status.rsp_free;
         default:  ;
      endcase
   end

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> state_ff == S_CLEAR)
      else $error("clearing pass did not start after reset");

   a_fill_not_dropped: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> !status.drop)
      else $error("dropped rectangle is being filled");

   a_scale_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> $past(state_ff) == S_SCALE && $past(step_ff) == SEL_H)
      else $error("scaling left before all four coordinates");

endmodule

// ----- rtl/clipped_rectangle_fill.sv -----
// clipped rectangle fill into a 128 x 64 RGB frame store
//
// req_chan (valid/ready) takes one item per handshake: req_type 0 fills a
// rectangle given in signed Q4.12 normalized units, req_type 1 reads one
// pixel at read_col/read_row. rsp_chan returns exactly one item for every
// request: the read colour, or fill_drawn for a fill.
// csr_we/csr_index/csr_wdata write screen_width, screen_height and x_offset;
// write them only while the block is idle.
// a read is decoded and then reads the store before its result is loaded; a
// fill runs a setup (decode, four height scalings on one shared multiplier,
// drain, clip, check) and then writes its pixels; a dropped fill goes from
// the check straight to its result. the single store port writes one pixel a
// cycle and so sets the fill rate. one item is worked on at a time; the next
// is taken the cycle after the previous result enters the output register.
// reset: configuration returns to 128 x 64, offset 8192, and a clearing pass
// writes zero to all 8192 pixels, one a cycle; no item is taken until it ends.
// a stalled rsp_chan holds its result in the output register; one more item
// can be taken and worked on, then the block waits until the result is taken
module clipped_rectangle_fill import crfill_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   crfill_req_if.sink            req_chan,
   crfill_rsp_if.source          rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   logic          req_ready;
   logic          rsp_valid;

   // request payload into one packed item
   assign req_item.req_type   = req_chan.req_type;
   assign req_item.rect_x     = req_chan.rect_x;
   assign req_item.rect_y     = req_chan.rect_y;
   assign req_item.rect_w     = req_chan.rect_w;
   assign req_item.rect_h     = req_chan.rect_h;
   assign req_item.fill_red   = req_chan.fill_red;
   assign req_item.fill_green = req_chan.fill_green;
   assign req_item.fill_blue  = req_chan.fill_blue;
   assign req_item.fill_alpha = req_chan.fill_alpha;
   assign req_item.read_col   = req_chan.read_col;
   assign req_item.read_row   = req_chan.read_row;
   assign req_chan.ready      = req_ready;

   // sequencer: clearing pass, scaling steps, raster fill, store read
   crfill_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // config registers, scaling multiplier, clipper, frame store, result register
   crfill_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.pixel_red   = rsp_item.pixel_red;
   assign rsp_chan.pixel_green = rsp_item.pixel_green;
   assign rsp_chan.pixel_blue  = rsp_item.pixel_blue;
   assign rsp_chan.fill_drawn  = rsp_item.fill_drawn;

endmodule

// ----- test/tb_clipped_rectangle_fill.sv -----
module tb_clipped_rectangle_fill;
   import crfill_pkg::*;

   // request kinds and the register index that the block does not decode
   localparam logic                 REQ_FILL   = 1'b0;
   localparam logic                 REQ_READ   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int DIRECTED_ITEMS  = 22;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int MAX_REPORTS     = 200;

   // keeps a copy of the frame store and the screen registers, works out the
   // response of every accepted item and compares the responses in order
   class frame_scoreboard;
      logic [PIX_W-1:0]  pixels [DEPTH];
      logic [SW_W-1:0]   screen_w;
      logic [SH_W-1:0]   screen_h;
      logic [XOFF_W-1:0] x_off;
      rsp_item_type      pending_results [$];
      int unsigned       mismatches;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         screen_w   = SCREEN_WIDTH_RESET;
         screen_h   = SCREEN_HEIGHT_RESET;
         x_off      = X_OFFSET_RESET;
         mismatches = 0;
      endfunction

      function int active_width();
         if (screen_w == 0) return 1;
         if (screen_w > MAX_WIDTH) return MAX_WIDTH;
         return int'(screen_w);
      endfunction

      function int active_height();
         if (screen_h == 0) return 1;
         if (screen_h > MAX_HEIGHT) return MAX_HEIGHT;
         return int'(screen_h);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SCREEN_WIDTH:  screen_w = data[SW_W-1:0];
            CSR_SCREEN_HEIGHT: screen_h = data[SH_W-1:0];
            CSR_X_OFFSET:      x_off    = data[XOFF_W-1:0];
            default: ;
         endcase
      endfunction

      // normalized value to pixels, both divisions truncate toward zero
      function longint to_pixels(longint q, longint h);
         longint p;
         p = (q * h) / (longint'(1) << FRAC_BITS);
         return p / 2;
      endfunction

      function void note_request(req_item_type it);
         rsp_item_type want;
         longint w, h, nx, ny, nw, nh, last_x, last_y, cx, cy;
         want = '0;
         if (it.req_type == REQ_READ) begin
            if (it.read_col < MAX_WIDTH && it.read_row < MAX_HEIGHT)
               {want.pixel_red, want.pixel_green, want.pixel_blue} =
                  pixels[int'(it.read_row) * MAX_WIDTH + int'(it.read_col)];
         end else begin
            w  = active_width();
            h  = active_height();
            nx = to_pixels(longint'(it.rect_x) + longint'(x_off), h);
            ny = to_pixels((longint'(1) << FRAC_BITS) - longint'(it.rect_y), h);
            nw = to_pixels(longint'(it.rect_w), h);
            nh = to_pixels(longint'(it.rect_h), h);
            if (nx < w && ny < h) begin
               if (nx < 0) begin
                  nw = nw + nx;
                  nx = 0;
               end
               if (ny < 0) begin
                  nh = nh + ny;
                  ny = 0;
               end
               if (nx + nw > w) nw = w - nx;
               if (ny + nh > h) nh = h - ny;
               if (it.fill_alpha >= ALPHA_MIN) begin
                  // an empty span still covers its first column or row
                  last_x = (nw > 0) ? nx + nw - 1 : nx;
                  last_y = (nh > 0) ? ny + nh - 1 : ny;
                  for (cx = nx; cx <= last_x; cx++)
                     for (cy = ny; cy <= last_y; cy++)
                        if (cx < MAX_WIDTH && cy < MAX_HEIGHT)
                           pixels[cy * MAX_WIDTH + cx] =
                              {it.fill_red, it.fill_green, it.fill_blue};
                  want.fill_drawn = 1'b1;
               end
            end
         end
         pending_results.push_back(want);
      endfunction

      function void report(string field, int want, int got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t response with nothing pending: expected none actual %h",
                        $time, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.pixel_red !== want.pixel_red)
            report("pixel_red", int'(want.pixel_red), int'(got.pixel_red));
         if (got.pixel_green !== want.pixel_green)
            report("pixel_green", int'(want.pixel_green), int'(got.pixel_green));
         if (got.pixel_blue !== want.pixel_blue)
            report("pixel_blue", int'(want.pixel_blue), int'(got.pixel_blue));
         if (got.fill_drawn !== want.fill_drawn)
            report("fill_drawn", int'(want.fill_drawn), int'(got.fill_drawn));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   crfill_req_if req_chan ();
   crfill_rsp_if rsp_chan ();

   frame_scoreboard frame_sb;
   int unsigned     results_taken;
   bit              held_off;

   clipped_rectangle_fill i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // idle length for either side: mostly none or short, now and then long
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // fill item; the read fields are don't-care and get random values
   function automatic req_item_type fill_req(int x, int y, int w, int h,
                                             logic [PIX_W-1:0] rgb, logic [7:0] alpha);
      req_item_type it;
      it.req_type   = REQ_FILL;
      it.rect_x     = 16'(x);
      it.rect_y     = 16'(y);
      it.rect_w     = 15'(w);
      it.rect_h     = 15'(h);
      {it.fill_red, it.fill_green, it.fill_blue} = rgb;
      it.fill_alpha = alpha;
      it.read_col   = 7'($urandom);
      it.read_row   = 6'($urandom);
      return it;
   endfunction

   // read item; the rectangle and colour fields carry random junk
   function automatic req_item_type read_req(int col, int row);
      req_item_type it;
      it = fill_req(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    24'($urandom), 8'($urandom));
      it.req_type = REQ_READ;
      it.read_col = 7'(col);
      it.read_row = 6'(row);
      return it;
   endfunction

   // random item: a third reads, a few pure noise, the rest fills aimed
   // around the active area of the current screen setting
   function automatic req_item_type make_request();
      req_item_type it;
      int unsigned  roll;
      int           w, h, step, tx, ty;
      it = fill_req(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    24'($urandom), 8'($urandom));
      it.req_type = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         it.req_type = REQ_READ;
         return it;
      end
      if (roll < 39) return it;
      it.req_type = REQ_FILL;
      w    = frame_sb.active_width();
      h    = frame_sb.active_height();
      // normalized units per pixel
      step = (2 << FRAC_BITS) / h;
      tx   = int'($urandom_range(0, w + 6)) - 4;
      ty   = int'($urandom_range(0, h + 6)) - 4;
      it.rect_x = 16'(clamp(longint'(tx) * step - longint'(frame_sb.x_off)
                            + longint'($urandom_range(0, step - 1)), -32768, 32767));
      it.rect_y = 16'(clamp((longint'(1) << FRAC_BITS) - longint'(ty) * step
                            - longint'($urandom_range(0, step - 1)), -32768, 32767));
      // mostly small spans, about one in fifty keeps its random full size
      if ($urandom_range(0, 49) != 0)
         it.rect_w = 15'(clamp(longint'($urandom_range(0, 8)) * step
                               + longint'($urandom_range(0, step - 1)), 0, 32767));
      if ($urandom_range(0, 49) != 0)
         it.rect_h = 15'(clamp(longint'($urandom_range(0, 8)) * step
                               + longint'($urandom_range(0, step - 1)), 0, 32767));
      if ($urandom_range(0, 99) < 85) it.fill_alpha = 8'($urandom_range(128, 255));
      else it.fill_alpha = 8'($urandom_range(0, 127));
      return it;
   endfunction

   // offer one item, note it when taken, then maybe leave a gap
   task automatic send_request(input req_item_type it, input bit gaps_on);
      int unsigned gap;
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= it.req_type;
      req_chan.rect_x     <= it.rect_x;
      req_chan.rect_y     <= it.rect_y;
      req_chan.rect_w     <= it.rect_w;
      req_chan.rect_h     <= it.rect_h;
      req_chan.fill_red   <= it.fill_red;
      req_chan.fill_green <= it.fill_green;
      req_chan.fill_blue  <= it.fill_blue;
      req_chan.fill_alpha <= it.fill_alpha;
      req_chan.read_col   <= it.read_col;
      req_chan.read_row   <= it.read_row;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      frame_sb.note_request(it);
      gap = gaps_on ? idle_cycles() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid and wait until every pending response is back
   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frame_sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // write all three screen registers, then the undecoded index;
   // unused upper data bits carry random junk
   task automatic program_screen(input logic [SW_W-1:0] w, input logic [SH_W-1:0] h,
                                 input logic [XOFF_W-1:0] xoff);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      int                    k;
      idx = '{CSR_SCREEN_WIDTH, CSR_SCREEN_HEIGHT, CSR_X_OFFSET, CSR_UNUSED};
      foreach (val[i]) val[i] = CSR_DATA_W'($urandom);
      val[0][SW_W-1:0]   = w;
      val[1][SH_W-1:0]   = h;
      val[2][XOFF_W-1:0] = xoff;
      for (k = 0; k < 4; k++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         frame_sb.set_register(idx[k], val[k]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // response side: random stalls, plus one long hold-off early on so the
   // block backs up and stops taking items
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      held_off = 1'b0;
      forever begin
         if (!held_off && results_taken >= 100) begin
            stall    = HOLD_OFF_CYCLES;
            held_off = 1'b1;
         end else begin
            stall = idle_cycles();
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   end

   // compare every response taken at a rising edge
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.pixel_red   = rsp_chan.pixel_red;
         got.pixel_green = rsp_chan.pixel_green;
         got.pixel_blue  = rsp_chan.pixel_blue;
         got.fill_drawn  = rsp_chan.fill_drawn;
         frame_sb.check_result(got);
         results_taken++;
      end
   end

   initial begin
      int phase;
      int n_items;
      frame_sb            = new();
      results_taken       = 0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_SCREEN_WIDTH;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_FILL;
      req_chan.rect_x     = '0;
      req_chan.rect_y     = '0;
      req_chan.rect_w     = '0;
      req_chan.rect_h     = '0;
      req_chan.fill_red   = '0;
      req_chan.fill_green = '0;
      req_chan.fill_blue  = '0;
      req_chan.fill_alpha = '0;
      req_chan.read_col   = '0;
      req_chan.read_row   = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         n_items = ITEMS_PER_PHASE;
         if (phase == 0) begin
            // reset screen: 128 x 64, one pixel per 128 units, offset 2.0
            n_items = ITEMS_PER_PHASE - DIRECTED_ITEMS;
            // store is cleared after reset
            send_request(read_req(0, 0), 1'b1);
            send_request(read_req(127, 63), 1'b1);
            // whole screen, both spans clipped at the far edges
            send_request(fill_req(-8192, 4096, 32767, 32767, 24'h123456, 8'd255), 1'b1);
            send_request(read_req(127, 63), 1'b1);
            // alpha just under the threshold leaves the screen alone
            send_request(fill_req(-8192, 4096, 32767, 32767, 24'hffffff, 8'd127), 1'b1);
            // zero size still paints one pixel, alpha at the threshold
            send_request(fill_req(0, 0, 0, 0, 24'habcdef, 8'd128), 1'b1);
            send_request(read_req(64, 32), 1'b1);
            send_request(read_req(65, 32), 1'b1);
            // starts exactly on the right edge, then exactly on the bottom
            send_request(fill_req(8192, 0, 1024, 1024, 24'h0000ff, 8'd255), 1'b1);
            send_request(fill_req(0, -4096, 1024, 1024, 24'h0000ff, 8'd255), 1'b1);
            // most negative x and most positive y: clipped left and top
            send_request(fill_req(-32768, 32767, 32767, 32767, 24'h00ff00, 8'd255), 1'b1);
            send_request(read_req(62, 31), 1'b1);
            send_request(read_req(63, 31), 1'b1);
            send_request(read_req(62, 32), 1'b1);
            // extreme x to the right, extreme y below
            send_request(fill_req(32767, 0, 512, 512, 24'hff00ff, 8'd255), 1'b1);
            send_request(fill_req(0, -32768, 512, 512, 24'hff00ff, 8'd255), 1'b1);
            // left of the screen with no width left: one column at zero
            send_request(fill_req(-9216, 4096, 0, 256, 24'hff0000, 8'd200), 1'b1);
            send_request(read_req(0, 1), 1'b1);
            send_request(read_req(1, 0), 1'b1);
            // small negative x that truncates to zero
            send_request(fill_req(-8256, 2048, 256, 256, 24'h808080, 8'd255), 1'b1);
            // near the bottom right corner, clipped right and bottom
            send_request(fill_req(7800, -3900, 32767, 32767, 24'hffffff, 8'd255), 1'b1);
            send_request(read_req(127, 63), 1'b1);
         end else begin
            drain_responses();
            case (phase)
               1: program_screen(8'd1, 7'd1, 15'd0);
               2: program_screen(8'd255, 7'd127, 15'd32767);
               3: program_screen(8'd0, 7'd0, XOFF_W'($urandom));
               4: program_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, X_OFFSET_RESET);
               5: program_screen(8'd1, 7'd64, XOFF_W'($urandom));
               default: program_screen(SW_W'($urandom), SH_W'($urandom), XOFF_W'($urandom));
            endcase
         end
         // phase four runs back to back with no sender gaps
         repeat (n_items) send_request(make_request(), phase != 4);
      end

      drain_responses();
      // give any stray response time to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frame_sb.pending_results.size() != 0)
         $display("%0t responses still pending: expected 0 actual %0d",
                  $time, frame_sb.pending_results.size());
      if (frame_sb.mismatches == 0 && frame_sb.pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run (every item a full-screen
   // fill under the longest stalls)
   initial begin
      #1500000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
